FILE: rtl/core/ctcss_dds_tone_generator_unit_assert.svh
// Assertion macros for the CTCSS tone generator, with empty forms for synthesis.
`ifndef CTCSS_DDS_TONE_GENERATOR_UNIT_ASSERT_SVH
`define CTCSS_DDS_TONE_GENERATOR_UNIT_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on clock, off during reset
`define CTCSS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ctcss tone generator: assertion failed");

// Next-cycle implication, sampled on clock, off during reset
`define CTCSS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ctcss tone generator: assertion failed");

`else

`define CTCSS_ASSERT_NOW(label, ante, cons)
`define CTCSS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/core/ctcss_pkg.sv
// Package: command codes, tuning word table and sine ROM for the CTCSS tone generator.
package ctcss_pkg;

   // Command codes carried in the kind field of a request beat
   typedef enum logic [2:0] {
      KIND_TICK    = 3'd0,
      KIND_TONE_ON = 3'd1,
      KIND_SELECT  = 3'd2,
      KIND_RESUME  = 3'd3,
      KIND_OFF     = 3'd4,
      KIND_TOGGLE  = 3'd5
   } kind_type;

   localparam int KIND_BITS  = 3;
   localparam int TONE_BITS  = 6;
   localparam int DUTY_BITS  = 8;
   localparam int TUNE_BITS  = 32;
   localparam int TUNE_LEN   = 39;
   localparam int WIDE_BITS  = 48;
   localparam int ROM_BITS   = 8;
   localparam int ROM_DEPTH  = 256;

   // Tuning words for a 32-bit accumulator; entry 0 is no tone
   localparam logic [TUNE_BITS-1:0] TUNE_TABLE [TUNE_LEN] = '{
      32'd0,        32'd9172440,  32'd9843260,  32'd10185515, 32'd10541460,
      32'd10911096, 32'd11294422, 32'd11691438, 32'd12115834, 32'd12526541,
      32'd12978317, 32'd13334263, 32'd13690208, 32'd14169366, 32'd14675903,
      32'd15182441, 32'd15716359, 32'd16263967, 32'd16838956, 32'd17427635,
      32'd18043694, 32'd18687134, 32'd19344264, 32'd20015084, 32'd20726975,
      32'd21452556, 32'd22205518, 32'd22985860, 32'd23793582, 32'd24628685,
      32'd25491168, 32'd26394722, 32'd27859574, 32'd28845269, 32'd29858344,
      32'd30898800, 32'd31980326, 32'd33102924, 32'd34266591
   };

   // One period of sine, offset binary, peak 254
   localparam logic [DUTY_BITS-1:0] SINE_ROM [ROM_DEPTH] = '{
      8'd127,8'd130,8'd133,8'd136,8'd139,8'd143,8'd146,8'd149,
      8'd152,8'd155,8'd158,8'd161,8'd164,8'd167,8'd170,8'd173,
      8'd176,8'd178,8'd181,8'd184,8'd187,8'd190,8'd192,8'd195,
      8'd198,8'd200,8'd203,8'd205,8'd208,8'd210,8'd212,8'd215,
      8'd217,8'd219,8'd221,8'd223,8'd225,8'd227,8'd229,8'd231,
      8'd233,8'd234,8'd236,8'd238,8'd239,8'd240,8'd242,8'd243,
      8'd244,8'd245,8'd247,8'd248,8'd249,8'd249,8'd250,8'd251,
      8'd252,8'd252,8'd253,8'd253,8'd253,8'd254,8'd254,8'd254,
      8'd254,8'd254,8'd254,8'd254,8'd253,8'd253,8'd253,8'd252,
      8'd252,8'd251,8'd250,8'd249,8'd249,8'd248,8'd247,8'd245,
      8'd244,8'd243,8'd242,8'd240,8'd239,8'd238,8'd236,8'd234,
      8'd233,8'd231,8'd229,8'd227,8'd225,8'd223,8'd221,8'd219,
      8'd217,8'd215,8'd212,8'd210,8'd208,8'd205,8'd203,8'd200,
      8'd198,8'd195,8'd192,8'd190,8'd187,8'd184,8'd181,8'd178,
      8'd176,8'd173,8'd170,8'd167,8'd164,8'd161,8'd158,8'd155,
      8'd152,8'd149,8'd146,8'd143,8'd139,8'd136,8'd133,8'd130,
      8'd127,8'd124,8'd121,8'd118,8'd115,8'd111,8'd108,8'd105,
      8'd102,8'd99, 8'd96, 8'd93, 8'd90, 8'd87, 8'd84, 8'd81,
      8'd78, 8'd76, 8'd73, 8'd70, 8'd67, 8'd64, 8'd62, 8'd59,
      8'd56, 8'd54, 8'd51, 8'd49, 8'd46, 8'd44, 8'd42, 8'd39,
      8'd37, 8'd35, 8'd33, 8'd31, 8'd29, 8'd27, 8'd25, 8'd23,
      8'd21, 8'd20, 8'd18, 8'd16, 8'd15, 8'd14, 8'd12, 8'd11,
      8'd10, 8'd9,  8'd7,  8'd6,  8'd5,  8'd5,  8'd4,  8'd3,
      8'd2,  8'd2,  8'd1,  8'd1,  8'd1,  8'd0,  8'd0,  8'd0,
      8'd0,  8'd0,  8'd0,  8'd0,  8'd1,  8'd1,  8'd1,  8'd2,
      8'd2,  8'd3,  8'd4,  8'd5,  8'd5,  8'd6,  8'd7,  8'd9,
      8'd10, 8'd11, 8'd12, 8'd14, 8'd15, 8'd16, 8'd18, 8'd20,
      8'd21, 8'd23, 8'd25, 8'd27, 8'd29, 8'd31, 8'd33, 8'd35,
      8'd37, 8'd39, 8'd42, 8'd44, 8'd46, 8'd49, 8'd51, 8'd54,
      8'd56, 8'd59, 8'd62, 8'd64, 8'd67, 8'd70, 8'd73, 8'd76,
      8'd78, 8'd81, 8'd84, 8'd87, 8'd90, 8'd93, 8'd96, 8'd99,
      8'd102,8'd105,8'd108,8'd111,8'd115,8'd118,8'd121,8'd124
   };

   // Look up the table word; tone numbers without an entry give zero
   function automatic logic [TUNE_BITS-1:0] tune_word(input logic [TONE_BITS-1:0] id);
      logic [TUNE_BITS-1:0] word;
      word = '0;
      if (id < TONE_BITS'(TUNE_LEN)) begin
         word = TUNE_TABLE[id];
      end
      return word;
   endfunction

endpackage

FILE: rtl/core/ctcss_req_if.sv
// Request channel interface: sample ticks and commands.
interface ctcss_req_if;
   logic                                valid;
   logic                                ready;
   logic [ctcss_pkg::KIND_BITS-1:0]     kind;
   logic [ctcss_pkg::TONE_BITS-1:0]     tone_id;

   modport source (output valid, output kind, output tone_id, input ready);
   modport sink   (input valid, input kind, input tone_id, output ready);
endinterface

FILE: rtl/core/ctcss_rsp_if.sv
// Response channel interface: duty value and tone status.
interface ctcss_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ctcss_pkg::DUTY_BITS-1:0]     pwm_duty;
   logic                                tone_active;
   logic [ctcss_pkg::TONE_BITS-1:0]     reported_tone;

   modport source (output valid, output pwm_duty, output tone_active,
                   output reported_tone, input ready);
   modport sink   (input valid, input pwm_duty, input tone_active,
                   input reported_tone, output ready);
endinterface

FILE: rtl/core/ctcss_dds_tone_generator_unit.sv
// The response beat is registered: it appears in the cycle after its request beat is accepted.
// Throughput: one beat per cycle; the path is one accumulator add feeding the sine ROM.
// The response register frees on the cycle it is taken, so a stalled output stalls input.
// Reset (synchronous, active high) clears the accumulator, tuning word, on/off state,
// selected tone, held duty and the response valid flag.
`include "ctcss_dds_tone_generator_unit_assert.svh"

module ctcss_dds_tone_generator_unit #(
   parameter int PHASE_BITS     = 32,
   parameter int SINE_ADDR_BITS = 8,
   parameter int NUM_TONES      = 39
) (
   input  logic              clock,
   input  logic              reset,
   ctcss_req_if.sink         req_chan,
   ctcss_rsp_if.source       rsp_chan
);

   localparam int TB = ctcss_pkg::TONE_BITS;
   localparam int RB = ctcss_pkg::ROM_BITS;

   // State
   logic [PHASE_BITS-1:0]               phase_ff, phase_in;
   logic [PHASE_BITS-1:0]               tuning_ff, tuning_in;
   logic                                enabled_ff, enabled_in;
   logic [TB-1:0]                       tone_ff, tone_in;
   logic [ctcss_pkg::DUTY_BITS-1:0]     duty_ff, duty_in;
   logic                                rsp_valid_ff;

   logic                                req_accept;
   logic [PHASE_BITS-1:0]               phase_sum;
   logic [RB-1:0]                       rom_addr;
   logic [ctcss_pkg::DUTY_BITS-1:0]     sine_sample;
   logic                                req_ok, sel_ok;
   logic [PHASE_BITS-1:0]               req_word, sel_word;

   // Tone number is usable when below the tone count
   function automatic logic tone_valid(input logic [TB-1:0] id);
      return {1'b0, id} < (TB+1)'(NUM_TONES);
   endfunction

   // Table word fitted to the accumulator width
   function automatic logic [PHASE_BITS-1:0] tone_word(input logic [TB-1:0] id);
      logic [ctcss_pkg::WIDE_BITS-1:0] wide;
      wide = ctcss_pkg::WIDE_BITS'(ctcss_pkg::tune_word(id));
      return wide[PHASE_BITS-1:0];
   endfunction

   // Accept while the response register is empty or being drained
   assign req_accept  = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;

   // Advance the accumulator and scale its top bits to the ROM address
   assign phase_sum = phase_ff + tuning_ff;

   generate
      if (SINE_ADDR_BITS >= RB) begin : g_addr_drop
         assign rom_addr = phase_sum[PHASE_BITS-1 -: RB];
      end else begin : g_addr_shift
         assign rom_addr = {phase_sum[PHASE_BITS-1 -: SINE_ADDR_BITS],
                            {(RB-SINE_ADDR_BITS){1'b0}}};
      end
   endgenerate

   assign sine_sample = ctcss_pkg::SINE_ROM[rom_addr];

   // Start-tone candidates for the requested and the selected number
   assign req_ok   = tone_valid(req_chan.tone_id);
   assign sel_ok   = tone_valid(tone_ff);
   assign req_word = tone_word(req_chan.tone_id);
   assign sel_word = tone_word(tone_ff);

   // Decode the command and form the next state
   always_comb begin
      phase_in   = phase_ff;
      tuning_in  = tuning_ff;
      enabled_in = enabled_ff;
      tone_in    = tone_ff;
      duty_in    = duty_ff;
      case (ctcss_pkg::kind_type'(req_chan.kind))
         ctcss_pkg::KIND_TICK: begin
            if (enabled_ff) begin
               phase_in = phase_sum;
               duty_in  = sine_sample;
            end
         end
         ctcss_pkg::KIND_TONE_ON: begin
            enabled_in = req_ok;
            tone_in    = req_ok ? req_chan.tone_id : '0;
            tuning_in  = req_ok ? req_word : '0;
         end
         ctcss_pkg::KIND_SELECT: begin
            if (enabled_ff) begin
               enabled_in = req_ok;
               tone_in    = req_ok ? req_chan.tone_id : '0;
               tuning_in  = req_ok ? req_word : '0;
            end else begin
               tone_in = req_chan.tone_id;
            end
         end
         ctcss_pkg::KIND_RESUME: begin
            enabled_in = sel_ok;
            tone_in    = sel_ok ? tone_ff : '0;
            tuning_in  = sel_ok ? sel_word : '0;
         end
         ctcss_pkg::KIND_OFF: begin
            enabled_in = 1'b0;
         end
         ctcss_pkg::KIND_TOGGLE: begin
            if (enabled_ff) begin
               enabled_in = 1'b0;
            end else begin
               enabled_in = sel_ok;
               tone_in    = sel_ok ? tone_ff : '0;
               tuning_in  = sel_ok ? sel_word : '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Update state on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         tuning_ff  <= '0;
         enabled_ff <= 1'b0;
         tone_ff    <= '0;
         duty_ff    <= '0;
      end else if (req_accept) begin
         phase_ff   <= phase_in;
         tuning_ff  <= tuning_in;
         enabled_ff <= enabled_in;
         tone_ff    <= tone_in;
         duty_ff    <= duty_in;
      end
   end

   // Hold the response beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pwm_duty      = duty_ff;
   assign rsp_chan.tone_active   = enabled_ff;
   assign rsp_chan.reported_tone = enabled_ff ? tone_ff : '0;

   // Checks
   `CTCSS_ASSERT_NOW(a_off_reports_none,
      rsp_valid_ff && !rsp_chan.tone_active,
      rsp_chan.reported_tone == '0)
   `CTCSS_ASSERT_NOW(a_on_tone_in_range, enabled_ff, tone_valid(tone_ff))
   `CTCSS_ASSERT_NEXT(a_tick_off_holds,
      req_accept && !enabled_ff && req_chan.kind == ctcss_pkg::KIND_TICK,
      $stable(phase_ff) && $stable(duty_ff))
   `CTCSS_ASSERT_NEXT(a_bad_tone_turns_off,
      req_accept && !req_ok && req_chan.kind == ctcss_pkg::KIND_TONE_ON,
      !enabled_ff && tuning_ff == '0)

endmodule

FILE: test/ctcss_dds_tone_generator_unit_test.sv
// Self-checking testbench for the CTCSS tone generator: directed and random beats.
module ctcss_dds_tone_generator_unit_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_W      = 32;
   localparam int TONE_COUNT   = 39;
   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_BEATS = 1650;
   localparam int STEADY_FIRST = 700;
   localparam int STEADY_LAST  = 1000;
   localparam int IDLE_PERCENT = 7;
   localparam int DRAIN_CYCLES = 4;
   localparam int STALL_LIMIT  = 500;
   localparam int PLAN_ROWS    = 27;
   localparam int KB           = ctcss_pkg::KIND_BITS;
   localparam int TB           = ctcss_pkg::TONE_BITS;
   localparam int DB           = ctcss_pkg::DUTY_BITS;

   // Kind codes the block leaves unused
   localparam logic [KB-1:0] KIND_SPARE_6 = 3'd6;
   localparam logic [KB-1:0] KIND_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [DB-1:0] pwm_duty;
      logic          tone_active;
      logic [TB-1:0] reported_tone;
   } tone_status_type;

   typedef struct packed {
      logic [KB-1:0]   kind;
      logic [TB-1:0]   tone_id;
      logic            fixed;
      tone_status_type status;
   } plan_row_type;

   // Directed beats; fixed rows carry their own status, the rest use the predictor
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      '{ctcss_pkg::KIND_TICK,    6'd0,  1'b1, '{8'd0,   1'b0, 6'd0}},
      '{ctcss_pkg::KIND_OFF,     6'd0,  1'b1, '{8'd0,   1'b0, 6'd0}},
      '{ctcss_pkg::KIND_TONE_ON, 6'd63, 1'b1, '{8'd0,   1'b0, 6'd0}},
      '{ctcss_pkg::KIND_TONE_ON, 6'd39, 1'b1, '{8'd0,   1'b0, 6'd0}},
      '{ctcss_pkg::KIND_TONE_ON, 6'd0,  1'b1, '{8'd0,   1'b1, 6'd0}},
      '{ctcss_pkg::KIND_TICK,    6'd0,  1'b1, '{8'd127, 1'b1, 6'd0}},
      '{ctcss_pkg::KIND_TONE_ON, 6'd38, 1'b1, '{8'd127, 1'b1, 6'd38}},
      '{ctcss_pkg::KIND_TICK,    6'd0,  1'b0, '0},
      '{ctcss_pkg::KIND_TICK,    6'd63, 1'b0, '0},
      '{ctcss_pkg::KIND_OFF,     6'd0,  1'b0, '0},
      '{ctcss_pkg::KIND_TICK,    6'd0,  1'b0, '0},
      '{ctcss_pkg::KIND_SELECT,  6'd1,  1'b0, '0},
      '{ctcss_pkg::KIND_RESUME,  6'd0,  1'b0, '0},
      '{ctcss_pkg::KIND_SELECT,  6'd38, 1'b0, '0},
      '{ctcss_pkg::KIND_TOGGLE,  6'd0,  1'b0, '0},
      '{ctcss_pkg::KIND_SELECT,  6'd50, 1'b0, '0},
      '{ctcss_pkg::KIND_RESUME,  6'd0,  1'b0, '0},
      '{ctcss_pkg::KIND_TOGGLE,  6'd0,  1'b0, '0},
      '{ctcss_pkg::KIND_TICK,    6'd0,  1'b0, '0},
      '{ctcss_pkg::KIND_TOGGLE,  6'd0,  1'b0, '0},
      '{ctcss_pkg::KIND_SELECT,  6'd63, 1'b0, '0},
      '{ctcss_pkg::KIND_TOGGLE,  6'd0,  1'b0, '0},
      '{KIND_SPARE_6,            6'd63, 1'b0, '0},
      '{KIND_SPARE_7,            6'd0,  1'b0, '0},
      '{ctcss_pkg::KIND_TONE_ON, 6'd42, 1'b0, '0},
      '{ctcss_pkg::KIND_TONE_ON, 6'd21, 1'b0, '0},
      '{ctcss_pkg::KIND_TICK,    6'd21, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic steady = 1'b0;
   int   errors = 0;
   int   quiet_cycles = 0;

   // Predictor state
   logic [PHASE_W-1:0] model_phase;
   logic [PHASE_W-1:0] model_tuning;
   logic               model_on;
   logic [TB-1:0]      model_tone;
   logic [DB-1:0]      model_duty;

   tone_status_type pending_status [$];

   ctcss_req_if req_chan ();
   ctcss_rsp_if rsp_chan ();

   ctcss_dds_tone_generator_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
   endtask

   // Turn a tone on by number; an invalid number forces the off state
   function automatic void start_tone(input logic [TB-1:0] id);
      if (id < TONE_COUNT) begin
         model_tone   = id;
         model_on     = 1'b1;
         model_tuning = (id < ctcss_pkg::TUNE_LEN) ? ctcss_pkg::TUNE_TABLE[id] : '0;
      end else begin
         model_tone   = '0;
         model_on     = 1'b0;
         model_tuning = '0;
      end
   endfunction

   // Apply one beat to the synthesiser state and return the status it reports
   function automatic tone_status_type advance_tone(input logic [KB-1:0] kind,
                                                    input logic [TB-1:0] id);
      tone_status_type st;
      case (kind)
         ctcss_pkg::KIND_TICK: begin
            if (model_on) begin
               model_phase = model_phase + model_tuning;
               model_duty  = ctcss_pkg::SINE_ROM[model_phase[PHASE_W-1 -: ctcss_pkg::ROM_BITS]];
            end
         end
         ctcss_pkg::KIND_TONE_ON: start_tone(id);
         ctcss_pkg::KIND_SELECT: begin
            if (model_on) start_tone(id);
            else model_tone = id;
         end
         ctcss_pkg::KIND_RESUME: start_tone(model_tone);
         ctcss_pkg::KIND_OFF: model_on = 1'b0;
         ctcss_pkg::KIND_TOGGLE: begin
            if (model_on) model_on = 1'b0;
            else start_tone(model_tone);
         end
         default: ;
      endcase
      st.pwm_duty      = model_duty;
      st.tone_active   = model_on;
      st.reported_tone = model_on ? model_tone : '0;
      return st;
   endfunction

   // Offer one beat, hold it until taken, then log the status it must produce
   task automatic send_beat(input logic [KB-1:0] kind,
                            input logic [TB-1:0] id,
                            input logic fixed, input tone_status_type fixed_status);
      tone_status_type st;
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.kind    <= kind;
      req_chan.tone_id <= id;
      do @(posedge clock); while (!req_chan.ready);
      st = advance_tone(kind, id);
      pending_status.push_back(fixed ? fixed_status : st);
   endtask

   // Pick a random beat, mostly ticks so the tone runs through whole periods
   task automatic random_beat(output logic [KB-1:0] kind,
                              output logic [TB-1:0] id);
      int pick;
      pick = $urandom_range(0, 99);
      id   = ($urandom_range(0, 4) == 0) ? TB'($urandom_range(0, 63))
                                         : TB'($urandom_range(1, TONE_COUNT - 1));
      if (pick < 70)      kind = ctcss_pkg::KIND_TICK;
      else if (pick < 80) kind = ctcss_pkg::KIND_TONE_ON;
      else if (pick < 85) kind = ctcss_pkg::KIND_SELECT;
      else if (pick < 89) kind = ctcss_pkg::KIND_RESUME;
      else if (pick < 93) kind = ctcss_pkg::KIND_OFF;
      else if (pick < 97) kind = ctcss_pkg::KIND_TOGGLE;
      else                kind = ($urandom_range(0, 1) == 0) ? KIND_SPARE_6 : KIND_SPARE_7;
   endtask

   // Stall the response side now and then, except in the steady stretch
   always @(posedge clock) begin
      rsp_chan.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Check each response beat against the oldest pending status
   always @(posedge clock) begin
      tone_status_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_status.size() == 0) begin
            report_mismatch("response beat with nothing pending");
         end else begin
            want = pending_status.pop_front();
            if (rsp_chan.pwm_duty !== want.pwm_duty)
               report_mismatch($sformatf("pwm_duty got %0d want %0d",
                                         rsp_chan.pwm_duty, want.pwm_duty));
            if (rsp_chan.tone_active !== want.tone_active)
               report_mismatch($sformatf("tone_active got %0d want %0d",
                                         rsp_chan.tone_active, want.tone_active));
            if (rsp_chan.reported_tone !== want.reported_tone)
               report_mismatch($sformatf("reported_tone got %0d want %0d",
                                         rsp_chan.reported_tone, want.reported_tone));
         end
      end
   end

   // Drop the run if no beat moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      logic [KB-1:0] kind;
      logic [TB-1:0] id;
      int sent;
      req_chan.valid   = 1'b0;
      req_chan.kind    = ctcss_pkg::KIND_TICK;
      req_chan.tone_id = '0;
      rsp_chan.ready   = 1'b0;
      model_phase  = '0;
      model_tuning = '0;
      model_on     = 1'b0;
      model_tone   = '0;
      model_duty   = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed plan
      for (int row = 0; row < PLAN_ROWS; row++) begin
         send_beat(PLAN[row].kind, PLAN[row].tone_id, PLAN[row].fixed, PLAN[row].status);
      end

      // Random beats; unused kinds do not count
      sent = 0;
      while (sent < RANDOM_BEATS) begin
         steady <= (sent >= STEADY_FIRST) && (sent < STEADY_LAST);
         random_beat(kind, id);
         send_beat(kind, id, 1'b0, '0);
         if (kind != KIND_SPARE_6 && kind != KIND_SPARE_7) sent++;
      end
      req_chan.valid <= 1'b0;
      steady <= 1'b0;

      // Drain outstanding responses, then settle
      while (pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/ctcss_pkg.sv
rtl/core/ctcss_req_if.sv
rtl/core/ctcss_rsp_if.sv
rtl/core/ctcss_dds_tone_generator_unit.sv
test/ctcss_dds_tone_generator_unit_test.sv
